// ===== rtl/qe_pkg.sv =====
// Shared constants, types and helpers for the quaternion to Euler angle core.
`default_nettype none
package qe_pkg;

  // Field formats
  localparam int IN_W     = 16;
  localparam int IN_FRAC  = 14;
  localparam int ANG_FRAC = 7;
  localparam int ROLL_W   = 16;
  localparam int PITCH_W  = 15;
  localparam int ZFRAC    = 24;

  // Internal widths
  localparam int ARG_W    = 36;   // atan2 argument, Q28 sums
  localparam int Z_W      = 34;   // angle accumulator, 2^-24 degree
  localparam int CX_W     = 45;   // CORDIC x/y datapath
  localparam int NX_W     = 37;   // atan2 args after sign fold
  localparam int SH_W     = 6;    // normalize shift
  localparam int NORM_TOP = 40;   // normalized magnitude in [2^40, 2^41)
  localparam int M_W      = 30;   // pitch sine magnitude, Q30
  localparam int SQ_N_W   = 62;   // radicand, padded to even width
  localparam int SQ_STEPS = SQ_N_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = 35;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LAT     = 4 + CORDIC_STEPS;

  localparam logic signed [Z_W-1:0] DEG90  = 34'sd1509949440;
  localparam logic signed [Z_W-1:0] DEG180 = 34'sd3019898880;
  localparam logic signed [PITCH_W-1:0] P90 = PITCH_W'(90 * (1 << ANG_FRAC));

  // atan(2^-i) in degrees * 2^24
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
    30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
    30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // atan2 special-case codes
  typedef enum logic [2:0] {
    SP_NONE,
    SP_ZERO,
    SP_P180,
    SP_P90,
    SP_M90
  } spec_t;

  // Round to nearest (ties up) and saturate to a w-bit signed field
  function automatic logic signed [15:0] field_sat(input logic signed [Z_W-1:0] z,
                                                   input int w);
    logic signed [Z_W:0] t;
    logic signed [Z_W:0] v;
    logic signed [Z_W:0] hi;
    logic signed [Z_W:0] lo;
    logic signed [Z_W:0] r;
    t  = (Z_W+1)'(z) + (Z_W+1)'(1 << (ZFRAC - ANG_FRAC - 1));
    v  = t >>> (ZFRAC - ANG_FRAC);
    hi = (Z_W+1)'((1 << (w - 1)) - 1);
    lo = -hi - 1;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qe_if.sv =====
// Input and result channel interfaces of the quaternion to Euler angle core.
`default_nettype none
interface qe_in_if;
  import qe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  quat_x;
  logic signed [IN_W-1:0]  quat_y;
  logic signed [IN_W-1:0]  quat_z;
  logic signed [IN_W-1:0]  quat_w;
  modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qe_out_if;
  import qe_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ROLL_W-1:0]  roll_deg;
  logic signed [PITCH_W-1:0] pitch_deg;
  logic signed [ROLL_W-1:0]  yaw_deg;
  logic                      gimbal_clamped;
  modport source(output valid, roll_deg, pitch_deg, yaw_deg, gimbal_clamped, input ready);
  modport sink(input valid, roll_deg, pitch_deg, yaw_deg, gimbal_clamped, output ready);
endinterface
`default_nettype wire

// ===== rtl/qe_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module qe_isqrt (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [qe_pkg::SQ_N_W-1:0]   n,
  output logic      [qe_pkg::ROOT_W-1:0]   root
);
  import qe_pkg::*;

  logic [REM_W-1:0]  rem_r  [SQ_STEPS-1];
  logic [SQ_N_W-1:0] nr_r   [SQ_STEPS-1];
  logic [ROOT_W-1:0] root_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [REM_W-1:0]  rp;
    logic [REM_W-1:0]  rs;
    logic [REM_W-1:0]  tr;
    logic [ROOT_W-1:0] qp;
    logic [SQ_N_W-1:0] np;

    if (k == 0) begin : g_first
      assign rp = '0;
      assign qp = '0;
      assign np = n;
    end else begin : g_next
      assign rp = rem_r[k-1];
      assign qp = root_r[k-1];
      assign np = nr_r[k-1];
    end

    // bring down the next bit pair, trial subtract 4*root+1
    assign rs = {rp[REM_W-3:0], np[SQ_N_W-1 -: 2]};
    assign tr = REM_W'({qp, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {qp[ROOT_W-2:0], (rs >= tr)};
      end
    end

    if (k < SQ_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= (rs >= tr) ? rs - tr : rs;
          nr_r[k]  <= np << 2;
        end
      end
    end
  end

  assign root = root_r[SQ_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/qe_atan2.sv =====
// Pipelined vectoring CORDIC atan2 in degrees * 2^24, with quadrant fold and normalize.
`default_nettype none
module qe_atan2 (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [qe_pkg::ARG_W-1:0]    y_i,
  input  wire logic signed [qe_pkg::ARG_W-1:0]    x_i,
  output logic signed      [qe_pkg::Z_W-1:0]      z_o
);
  import qe_pkg::*;

  // fold stage
  spec_t                  sp0_c, sp0_r, sp1_r, sp2_r, sp3_r;
  logic signed [NX_W-1:0] x0_c, y0_c, x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic signed [Z_W-1:0]  z0_c, z0_r, z1_r, z2_r, z3_r;
  logic [NX_W-1:0]        ay0_c, mx1_c, mx1_r;
  logic [SH_W-1:0]        p_c, sh2_r;
  logic signed [CX_W-1:0] x3_r, y3_r;

  always_comb begin
    x0_c = NX_W'(x_i);
    y0_c = NX_W'(y_i);
    z0_c = '0;
    if (y_i == '0) sp0_c = x_i[ARG_W-1] ? SP_P180 : SP_ZERO;
    else if (x_i == '0) sp0_c = y_i[ARG_W-1] ? SP_M90 : SP_P90;
    else sp0_c = SP_NONE;
    if (x_i[ARG_W-1]) begin
      x0_c = -x0_c;
      y0_c = -y0_c;
      z0_c = y_i[ARG_W-1] ? -DEG180 : DEG180;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp0_r <= sp0_c;
      x0_r  <= x0_c;
      y0_r  <= y0_c;
      z0_r  <= z0_c;
    end
  end

  // magnitude for normalization
  always_comb begin
    ay0_c = y0_r[NX_W-1] ? NX_W'(-y0_r) : NX_W'(y0_r);
    mx1_c = (NX_W'(x0_r) > ay0_c) ? NX_W'(x0_r) : ay0_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp1_r <= sp0_r;
      mx1_r <= mx1_c;
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      z1_r  <= z0_r;
    end
  end

  // leading one position, shift count
  always_comb begin
    p_c = '0;
    for (int i = 0; i < NX_W; i++) begin
      if (mx1_r[i]) p_c = SH_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp2_r <= sp1_r;
      sh2_r <= SH_W'(NORM_TOP) - p_c;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
    end
  end

  // normalize into [2^40, 2^41)
  always_ff @(posedge clk) begin
    if (en) begin
      sp3_r <= sp2_r;
      x3_r  <= CX_W'(x2_r) <<< sh2_r;
      y3_r  <= CX_W'(y2_r) <<< sh2_r;
      z3_r  <= z2_r;
    end
  end

  // CORDIC micro-rotations, one per stage
  logic signed [CX_W-1:0] cx_r [CORDIC_STEPS-1];
  logic signed [CX_W-1:0] cy_r [CORDIC_STEPS-1];
  logic signed [Z_W-1:0]  cz_r [CORDIC_STEPS];
  spec_t                  csp_r [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    logic signed [CX_W-1:0] xp, yp, xs, ys;
    logic signed [Z_W-1:0]  zp;
    spec_t                  spp;

    if (k == 0) begin : g_first
      assign xp  = x3_r;
      assign yp  = y3_r;
      assign zp  = z3_r;
      assign spp = sp3_r;
    end else begin : g_next
      assign xp  = cx_r[k-1];
      assign yp  = cy_r[k-1];
      assign zp  = cz_r[k-1];
      assign spp = csp_r[k-1];
    end

    assign xs = xp >>> k;
    assign ys = yp >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        csp_r[k] <= spp;
        cz_r[k]  <= yp[CX_W-1] ? zp - Z_W'(ATAN_TAB[k]) : zp + Z_W'(ATAN_TAB[k]);
      end
    end

    if (k < CORDIC_STEPS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          cx_r[k] <= yp[CX_W-1] ? xp - ys : xp + ys;
          cy_r[k] <= yp[CX_W-1] ? yp + xs : yp - xs;
        end
      end
    end
  end

  // special cases override the rotation result
  always_comb begin
    unique case (csp_r[CORDIC_STEPS-1])
      SP_ZERO: z_o = '0;
      SP_P180: z_o = DEG180;
      SP_P90:  z_o = DEG90;
      SP_M90:  z_o = -DEG90;
      default: z_o = cz_r[CORDIC_STEPS-1];
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler_degrees_core.sv =====
// Top level: quaternion to roll/pitch/yaw in degrees, fully pipelined.
//
//  channel | dir | handshake          | payload
//  in_if   | in  | valid/ready        | quat_x, quat_y, quat_z, quat_w (Q1.14)
//  out_if  | out | valid/ready        | roll_deg, pitch_deg, yaw_deg, gimbal_clamped
//
// One beat per cycle sustained unless out_if stalls and the skid entry fills.
// Depth is set by the 31-stage square root feeding the 20-stage pitch CORDIC.
// Synchronous active-low reset clears the valid bits and the output skid buffer.
// A stall on out_if first fills the skid entry, then freezes the whole pipeline;
// the skid entry keeps in_if.ready registered, so no beat is dropped or repeated.
// Each time the skid entry drains, in_if.ready stays low for that one cycle.
`default_nettype none
module quaternion_to_euler_degrees_core (
  input  wire logic clk,
  input  wire logic rst_n,
  qe_in_if.sink     in_if,
  qe_out_if.source  out_if
);
  import qe_pkg::*;

  localparam int I_SQ   = 3 + SQ_STEPS;              // sqrt output stage index
  localparam int I_OUT  = I_SQ + ATAN_LAT;           // final stage index
  localparam int LINE_N = I_OUT + 1;
  localparam int RY_DLY = I_OUT - (1 + ATAN_LAT);    // roll/yaw alignment
  localparam logic signed [ARG_W-1:0]  ONE    = ARG_W'(1) <<< (2 * IN_FRAC);
  localparam logic [SQ_N_W-1:0]        SQ_ONE = SQ_N_W'(1) << (2 * M_W);

  logic en;
  logic sk_full_r;
  logic out_v_r;

  // whole pipeline advances unless the output buffer is full
  assign en          = !sk_full_r;
  assign in_if.ready = en;

  // valid, clamp and sign travel with the beat
  logic [LINE_N-1:0] vld_r;
  logic [LINE_N-1:1] cl_r;
  logic [LINE_N-1:1] ng_r;

  // stage 1: products
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= in_if.quat_w * in_if.quat_x;
      yz_r <= in_if.quat_y * in_if.quat_z;
      xx_r <= in_if.quat_x * in_if.quat_x;
      yy_r <= in_if.quat_y * in_if.quat_y;
      wz_r <= in_if.quat_w * in_if.quat_z;
      xy_r <= in_if.quat_x * in_if.quat_y;
      zz_r <= in_if.quat_z * in_if.quat_z;
      wy_r <= in_if.quat_w * in_if.quat_y;
      zx_r <= in_if.quat_z * in_if.quat_x;
    end
  end

  // stage 2: sine/cosine terms, pitch sine magnitude
  logic signed [ARG_W-1:0] sinr_c, cosr_c, siny_c, cosy_c, sinp_c;
  logic [ARG_W-1:0]        smag_c;
  logic                    clamp_c;
  logic signed [ARG_W-1:0] sinr_r, cosr_r, siny_r, cosy_r;
  logic [M_W-1:0]          m2_r, m3_r, m4_r;

  always_comb begin
    sinr_c  = (ARG_W'(wx_r) + ARG_W'(yz_r)) <<< 1;
    cosr_c  = ONE - ((ARG_W'(xx_r) + ARG_W'(yy_r)) <<< 1);
    siny_c  = (ARG_W'(wz_r) + ARG_W'(xy_r)) <<< 1;
    cosy_c  = ONE - ((ARG_W'(yy_r) + ARG_W'(zz_r)) <<< 1);
    sinp_c  = (ARG_W'(wy_r) - ARG_W'(zx_r)) <<< 1;
    smag_c  = sinp_c[ARG_W-1] ? ARG_W'(-sinp_c) : ARG_W'(sinp_c);
    clamp_c = smag_c >= ARG_W'(ONE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sinr_r <= sinr_c;
      cosr_r <= cosr_c;
      siny_r <= siny_c;
      cosy_r <= cosy_c;
      m2_r   <= {smag_c[M_W-3:0], 2'b00};
    end
  end

  // stages 3-4: 1 - s^2 in Q60
  logic [2*M_W-1:0]  mm_r;
  logic [SQ_N_W-1:0] n_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mm_r <= m2_r * m2_r;
      m3_r <= m2_r;
      n_r  <= SQ_ONE - SQ_N_W'(mm_r);
      m4_r <= m3_r;
    end
  end

  // square root and matching delay of the sine
  logic [ROOT_W-1:0] root;
  logic [M_W-1:0]    ml_r [SQ_STEPS];

  qe_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .n    (n_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ml_r[0] <= m4_r;
      for (int i = 1; i < SQ_STEPS; i++) ml_r[i] <= ml_r[i-1];
    end
  end

  // three atan2 units
  logic signed [ARG_W-1:0] py_c, px_c;
  logic signed [Z_W-1:0]   roll_z, yaw_z, pitch_z;

  assign py_c = ng_r[I_SQ] ? -ARG_W'(ml_r[SQ_STEPS-1]) : ARG_W'(ml_r[SQ_STEPS-1]);
  assign px_c = ARG_W'(root);

  qe_atan2 u_roll  (.clk(clk), .en(en), .y_i(sinr_r), .x_i(cosr_r), .z_o(roll_z));
  qe_atan2 u_yaw   (.clk(clk), .en(en), .y_i(siny_r), .x_i(cosy_r), .z_o(yaw_z));
  qe_atan2 u_pitch (.clk(clk), .en(en), .y_i(py_c),   .x_i(px_c),   .z_o(pitch_z));

  // roll/yaw wait for pitch
  logic signed [ROLL_W-1:0] rd_r [RY_DLY];
  logic signed [ROLL_W-1:0] yd_r [RY_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r[0] <= field_sat(roll_z, ROLL_W);
      yd_r[0] <= field_sat(yaw_z, ROLL_W);
      for (int i = 1; i < RY_DLY; i++) begin
        rd_r[i] <= rd_r[i-1];
        yd_r[i] <= yd_r[i-1];
      end
    end
  end

  // valid line and side flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LINE_N-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl_r <= {cl_r[LINE_N-2:1], clamp_c};
      ng_r <= {ng_r[LINE_N-2:1], sinp_c[ARG_W-1]};
    end
  end

  // final beat
  logic                      pipe_v;
  logic signed [PITCH_W-1:0] pitch_c;
  logic signed [16-1:0]      pfield_c;

  assign pipe_v   = vld_r[I_OUT];
  assign pfield_c = field_sat(pitch_z, PITCH_W);
  assign pitch_c  = cl_r[I_OUT] ? (ng_r[I_OUT] ? -P90 : P90) : pfield_c[PITCH_W-1:0];

  // output register plus skid entry
  logic signed [ROLL_W-1:0]  o_roll_r, o_yaw_r, s_roll_r, s_yaw_r;
  logic signed [PITCH_W-1:0] o_pitch_r, s_pitch_r;
  logic                      o_cl_r, s_cl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      sk_full_r <= 1'b0;
    end else if (out_v_r && !out_if.ready) begin
      if (en && pipe_v) sk_full_r <= 1'b1;
    end else if (sk_full_r) begin
      out_v_r   <= 1'b1;
      sk_full_r <= 1'b0;
    end else begin
      out_v_r <= en && pipe_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_if.ready) begin
      if (en) begin
        s_roll_r  <= rd_r[RY_DLY-1];
        s_yaw_r   <= yd_r[RY_DLY-1];
        s_pitch_r <= pitch_c;
        s_cl_r    <= cl_r[I_OUT];
      end
    end else if (sk_full_r) begin
      o_roll_r  <= s_roll_r;
      o_yaw_r   <= s_yaw_r;
      o_pitch_r <= s_pitch_r;
      o_cl_r    <= s_cl_r;
    end else begin
      o_roll_r  <= rd_r[RY_DLY-1];
      o_yaw_r   <= yd_r[RY_DLY-1];
      o_pitch_r <= pitch_c;
      o_cl_r    <= cl_r[I_OUT];
    end
  end

  assign out_if.valid          = out_v_r;
  assign out_if.roll_deg       = o_roll_r;
  assign out_if.pitch_deg      = o_pitch_r;
  assign out_if.yaw_deg        = o_yaw_r;
  assign out_if.gimbal_clamped = o_cl_r;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_full_r |-> out_v_r)
    else $error("skid entry held without output beat");

  a_clamp_is_90: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && o_cl_r) |-> (o_pitch_r == P90 || o_pitch_r == -P90))
    else $error("clamped pitch not at +-90");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (o_pitch_r <= P90 && o_pitch_r >= -P90))
    else $error("pitch outside +-90");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && pipe_v) |=> pipe_v)
    else $error("beat lost at pipeline tail during stall");

endmodule
`default_nettype wire

// ===== tb/sv/qe_scoreboard.sv =====
// Scoreboard for the quaternion to Euler angle core: predicts roll/pitch/yaw per beat.
package qe_scoreboard_pkg;
  import qe_pkg::*;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamp;
  } euler_t;

  localparam longint ZDEG90  = 64'sd1509949440;
  localparam longint ZDEG180 = 64'sd3019898880;

  class euler_scoreboard;
    euler_t pending[$];
    int     mismatches;

    function new();
      mismatches = 0;
    endfunction

    // atan(2^-i) in 2^-24 degree
    static function longint atan_step(int i);
      longint t [16];
      t = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
            15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
            117342, 58671, 29335};
      return t[i];
    endfunction

    // vectoring atan2, angle in 2^-24 degree
    static function longint angle_of(longint sy, longint cx);
      longint z, mx, ax, ay, xs, ys;
      z = 0;
      if (sy == 0) return (cx >= 0) ? 0 : ZDEG180;
      if (cx == 0) return (sy > 0) ? ZDEG90 : -ZDEG90;
      if (cx < 0) begin
        z  = (sy >= 0) ? ZDEG180 : -ZDEG180;
        cx = -cx;
        sy = -sy;
      end
      ax = (cx < 0) ? -cx : cx;
      ay = (sy < 0) ? -sy : sy;
      mx = (ax > ay) ? ax : ay;
      while (mx >= (64'sd1 << 41)) begin
        mx = mx >> 1;
        cx = cx >>> 1;
        sy = sy >>> 1;
      end
      while (mx < (64'sd1 << 40)) begin
        mx = mx << 1;
        cx = cx * 2;
        sy = sy * 2;
      end
      for (int i = 0; i < 16; i++) begin
        xs = cx >>> i;
        ys = sy >>> i;
        if (sy >= 0) begin
          cx += ys; sy -= xs; z += atan_step(i);
        end else begin
          cx -= ys; sy += xs; z -= atan_step(i);
        end
      end
      return z;
    endfunction

    static function longint floor_root(longint n);
      longint res, b;
      res = 0;
      b = 64'sd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // round half up to 7 fraction bits, saturate to w bits
    static function longint to_deg(longint z, int w);
      longint v, hi;
      v  = (z + (64'sd1 << 16)) >>> 17;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v;
    endfunction

    function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                            logic signed [15:0] qz, logic signed [15:0] qw);
      longint x, y, z, w, one, sp, m, c, pz;
      euler_t e;
      x = qx; y = qy; z = qz; w = qw;
      one = 64'sd1 << 28;
      sp = 2 * (w * y - z * x);
      e.clamp = 0;
      if (((sp < 0) ? -sp : sp) >= one) begin
        e.clamp = 1;
        pz = (sp < 0) ? -ZDEG90 : ZDEG90;
      end else begin
        m = ((sp < 0) ? -sp : sp) << 2;
        c = floor_root((64'sd1 << 60) - m * m);
        pz = angle_of((sp < 0) ? -m : m, c);
      end
      e.roll  = 16'(to_deg(angle_of(2 * (w * x + y * z), one - 2 * (x * x + y * y)), 16));
      e.pitch = 15'(to_deg(pz, 15));
      e.yaw   = 16'(to_deg(angle_of(2 * (w * z + x * y), one - 2 * (y * y + z * z)), 16));
      pending.push_back(e);
    endfunction

    function void check_angles(euler_t got);
      euler_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat: roll %0d pitch %0d yaw %0d",
               got.roll, got.pitch, got.yaw);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (got.roll !== e.roll) begin
        $error("roll_deg expected %0d actual %0d", e.roll, got.roll);
        mismatches++;
      end
      if (got.pitch !== e.pitch) begin
        $error("pitch_deg expected %0d actual %0d", e.pitch, got.pitch);
        mismatches++;
      end
      if (got.yaw !== e.yaw) begin
        $error("yaw_deg expected %0d actual %0d", e.yaw, got.yaw);
        mismatches++;
      end
      if (got.clamp !== e.clamp) begin
        $error("gimbal_clamped expected %0b actual %0b", e.clamp, got.clamp);
        mismatches++;
      end
    endfunction
  endclass
endpackage

// ===== tb/sv/tb_quaternion_to_euler_degrees_core.sv =====
// Testbench top: drives quaternions into the core and checks the Euler angles.
module tb_quaternion_to_euler_degrees_core;
  timeunit 1ns;
  timeprecision 1ps;
  import qe_pkg::*;
  import qe_scoreboard_pkg::*;

  localparam int N_RANDOM   = 1830;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  bit   stim_done;
  bit   calm;       // no idling in the last part of the run
  bit   hold_off;   // long receiver stall
  int   sent;

  qe_in_if  in_ch();
  qe_out_if out_ch();

  quaternion_to_euler_degrees_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  euler_scoreboard angles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // random component: mostly within Q1.14 range, sometimes any pattern
  function automatic logic signed [15:0] rand_comp();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // one beat on the input channel, with random idle bursts
  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.quat_x <= qx;
    in_ch.quat_y <= qy;
    in_ch.quat_z <= qz;
    in_ch.quat_w <= qw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    angles.note_quat(qx, qy, qz, qw);
    sent++;
  endtask

  // input stimulus
  initial begin
    logic signed [15:0] ex [6];
    logic signed [15:0] a, b;
    int s;
    angles = new();
    ex = '{16'sd0, 16'sd16384, -16'sd16384, 16'sh7fff, -16'sh8000, 16'sd11585};
    in_ch.valid <= 1'b0;
    in_ch.quat_x <= '0; in_ch.quat_y <= '0; in_ch.quat_z <= '0; in_ch.quat_w <= '0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: identity, zero, half turns, gimbal lock, extremes, non-unit
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 11585, 0, 11585);
    send_quat(0, -11585, 0, 11585);
    send_quat(11585, 0, 0, 11585);
    send_quat(0, 0, 11585, -11585);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_quat(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff);
    send_quat(16'shffff, 16'sh5555, 16'shaaaa, 16'sh0001);
    send_quat(0, 8192, 0, 8192);
    for (int i = 0; i < 8; i++)
      send_quat(ex[$urandom_range(0, 5)], ex[$urandom_range(0, 5)],
                ex[$urandom_range(0, 5)], ex[$urandom_range(0, 5)]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) calm = 1;
      s = $urandom_range(0, 9);
      if (s == 0) begin
        // near gimbal lock: w*y - z*x around +1/2 or -1/2
        a = 16'($signed($urandom_range(11000, 12100)));
        b = 16'($signed($urandom_range(0, 400)) - 200);
        send_quat(b, a, b, ($urandom_range(0, 1) != 0) ? a : -a);
      end else if (s == 1) begin
        send_quat(0, 0, rand_comp(), rand_comp());
      end else begin
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // one long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (sent == 300);
    hold_off = 1;
    for (int c = 0; c < 150; c++) @(posedge clk);
    hold_off = 0;
  end

  // result side: random ready bursts, check every accepted beat
  initial begin
    euler_t got;
    int idle;
    idle = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) out_ch.ready <= 1'b0;
      else if (idle > 0) begin
        out_ch.ready <= 1'b0;
        idle--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        idle = $urandom_range(0, 2);
      end else out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.roll  = out_ch.roll_deg;
        got.pitch = out_ch.pitch_deg;
        got.yaw   = out_ch.yaw_deg;
        got.clamp = out_ch.gimbal_clamped;
        angles.check_angles(got);
      end
    end
  end

  // watchdog and end of run
  initial begin
    int quiet;
    quiet = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (stim_done && angles.pending.size() == 0) break;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
    repeat (100) @(posedge clk);
    if (angles.mismatches == 0 && angles.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/qe_pkg.sv
rtl/qe_if.sv
rtl/qe_isqrt.sv
rtl/qe_atan2.sv
rtl/quaternion_to_euler_degrees_core.sv
tb/sv/qe_scoreboard.sv
tb/sv/tb_quaternion_to_euler_degrees_core.sv
